@@ hw/rtl/sbds_pkg.sv @@
// sbds_pkg: shared types, constants and divide helpers for the serial clock divider search
// no dependencies

package sbds_pkg;

    localparam int ClkW   = 32;
    localparam int RateW  = 30;
    localparam int NumPre = 4;
    localparam int NumScl = 16;

    // divisor of one candidate pair
    typedef struct packed {
        logic [1:0] pre;
        logic [3:0] scl;
    } pair_t;

    // request carried down the pipe
    typedef struct packed {
        logic [ClkW-1:0] clk_hz;
        logic [ClkW-1:0] req_hz;
    } req_t;

    // best candidate so far
    typedef struct packed {
        logic [1:0]       pre;
        logic [3:0]       scl;
        logic [RateW-1:0] rate;
        logic             found;
    } best_t;

    // result item
    typedef struct packed {
        logic [1:0]       pre;
        logic [3:0]       scl;
        logic [RateW-1:0] rate;
        logic             above;
        logic             zero;
    } res_t;

    // floor(clk / 2) by a shift; floor(clk / 3), clk / 5, clk / 7 through reciprocal multiplies with correction
    function automatic logic [ClkW-1:0] div_odd(input logic [ClkW-1:0] x, input logic [1:0] p);
        logic [ClkW-1:0] q;
        logic [ClkW+2:0] prod;
        logic [ClkW+2:0] rem;
        logic [2:0]      d;
        q = '0;
        prod = '0;
        rem = '0;
        d = 3'd2;
        unique case (p)
            2'd0: begin q = x >> 1; d = 3'd2; end
            2'd1: begin q = ClkW'((64'(x) * 64'h0000_0000_AAAA_AAAB) >> 33); d = 3'd3; end
            2'd2: begin q = ClkW'((64'(x) * 64'h0000_0000_CCCC_CCCD) >> 34); d = 3'd5; end
            default: begin q = ClkW'((64'(x) * 64'h0000_0000_9249_2493) >> 34); d = 3'd7; end
        endcase
        prod = (ClkW+3)'(q) * (ClkW+3)'(d);
        rem  = (ClkW+3)'(x) - prod;
        if (prod > (ClkW+3)'(x))
            q = q - ClkW'(1);
        else if (rem >= (ClkW+3)'(d))
            q = q + ClkW'(1);
        return q;
    endfunction

    // scaler as a right shift after an optional /3 step (6 = 2 * 3)
    function automatic logic [3:0] scl_shift(input logic [3:0] s);
        logic [3:0] sh;
        unique case (s)
            4'd0: sh = 4'd1;
            4'd1: sh = 4'd2;
            4'd2: sh = 4'd1;
            4'd3: sh = 4'd3;
            default: sh = s;
        endcase
        return sh;
    endfunction

endpackage

@@ hw/rtl/spi_baud_divider_search.sv @@
// spi_baud_divider_search: top level of the serial clock divider search
// depends on sbds_pkg, sbds_pre_stage, sbds_row_select, sbds_merge

// Finds the prescaler (/2,/3,/5,/7) and scaler (/2 to /32768) pair giving the
// fastest serial clock not above the request, first pair in prescaler-major
// order on a tie, or the slowest pair (3, 15) when none fits. The pipe is four
// register stages deep (two reciprocal divide stages, row select, merge), and
// one transfer is taken every cycle unless the output stalls. The whole pipe
// advances only when the output register is free or being taken, so a stall
// holds every stage in place.
module spi_baud_divider_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // clock_hz [31:0], target_hz [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // prescaler_code, scaler_code, achieved_hz,
                                       // above_request, zero_rate, zero pad
);
    import sbds_pkg::*;

    logic            en;
    req_t            req_in;
    logic            v1;
    req_t            r1;
    logic [ClkW-1:0] q  [NumPre];
    logic [ClkW-1:0] q3 [NumPre];
    logic            v2;
    req_t            r2;
    best_t           best [NumPre];
    logic            v3;
    res_t            res;

    // pipe moves when the output slot is empty or drained this cycle
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign req_in.clk_hz = s_axis_tdata[31:0];
    assign req_in.req_hz = s_axis_tdata[63:32];

    sbds_pre_stage u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_req    (req_in),
        .out_valid (v1),
        .out_req   (r1),
        .out_q     (q),
        .out_q3    (q3)
    );

    sbds_row_select u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1),
        .in_req    (r1),
        .in_q      (q),
        .in_q3     (q3),
        .out_valid (v2),
        .out_req   (r2),
        .out_best  (best)
    );

    sbds_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2),
        .in_req    (r2),
        .in_best   (best),
        .out_valid (v3),
        .out_res   (res)
    );

    assign m_axis_tvalid = v3;
    assign m_axis_tdata  = {2'b00, res.zero, res.above, res.rate, res.scl, res.pre};

endmodule

@@ hw/rtl/sbds_pre_stage.sv @@
// sbds_pre_stage: divides the clock by each prescaler, and by prescaler * 3 for scaler /6
// depends on sbds_pkg

module sbds_pre_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  sbds_pkg::req_t       in_req,
    output logic                 out_valid,
    output sbds_pkg::req_t       out_req,
    output logic [sbds_pkg::ClkW-1:0] out_q  [sbds_pkg::NumPre],
    output logic [sbds_pkg::ClkW-1:0] out_q3 [sbds_pkg::NumPre]
);
    import sbds_pkg::*;

    logic            valid_reg;
    req_t            req_reg;
    logic [ClkW-1:0] q_reg  [NumPre];
    logic [ClkW-1:0] q_next [NumPre];
    logic [ClkW-1:0] q3_reg [NumPre];

    // first stage: clk / p
    always_comb
    begin
        for (int i = 0; i < NumPre; i++)
        begin
            q_next[i] = div_odd(in_req.clk_hz, 2'(i));
        end
    end

    logic            v2_reg;
    req_t            req2_reg;
    logic [ClkW-1:0] q2_reg [NumPre];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
            v2_reg    <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req_reg  <= in_req;
            q_reg    <= q_next;
            req2_reg <= req_reg;
            q2_reg   <= q_reg;
            // floor(floor(c/p)/3) == floor(c/(3p))
            for (int i = 0; i < NumPre; i++)
            begin
                q3_reg[i] <= div_odd(q_reg[i], 2'd1);
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_req   = req2_reg;
    assign out_q     = q2_reg;
    assign out_q3    = q3_reg;

endmodule

@@ hw/rtl/sbds_row_select.sv @@
// sbds_row_select: per prescaler row, picks the fastest fitting scaler
// depends on sbds_pkg

module sbds_row_select (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  sbds_pkg::req_t       in_req,
    input  logic [sbds_pkg::ClkW-1:0] in_q  [sbds_pkg::NumPre],
    input  logic [sbds_pkg::ClkW-1:0] in_q3 [sbds_pkg::NumPre],
    output logic                 out_valid,
    output sbds_pkg::req_t       out_req,
    output sbds_pkg::best_t      out_best [sbds_pkg::NumPre]
);
    import sbds_pkg::*;

    logic  valid_reg;
    req_t  req_reg;
    best_t best_reg  [NumPre];
    best_t best_next [NumPre];

    // rates fall with scaler index except /6 vs /4 and /8: still strictly ordered
    // (4 < 6 < 8), so the first fitting scaler in order is the fastest fitting one
    always_comb
    begin
        logic [ClkW-1:0] r;
        for (int i = 0; i < NumPre; i++)
        begin
            // nothing fits: keep the slowest scaler's rate for the fallback
            best_next[i] = '{pre: 2'(i), scl: 4'd15, rate: RateW'(in_q[i] >> 15),
                             found: 1'b0};
            for (int s = NumScl - 1; s >= 0; s--)
            begin
                if (s == 2)
                    r = in_q3[i] >> 1;
                else
                    r = in_q[i] >> scl_shift(4'(s));
                if (r != '0 && r <= in_req.req_hz)
                    best_next[i] = '{pre: 2'(i), scl: 4'(s), rate: RateW'(r), found: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req_reg  <= in_req;
            best_reg <= best_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;
    assign out_best  = best_reg;

endmodule

@@ hw/rtl/sbds_merge.sv @@
// sbds_merge: merges the four row winners, first row wins ties, builds the result
// depends on sbds_pkg

module sbds_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  sbds_pkg::req_t       in_req,
    input  sbds_pkg::best_t      in_best [sbds_pkg::NumPre],
    output logic                 out_valid,
    output sbds_pkg::res_t       out_res
);
    import sbds_pkg::*;

    logic valid_reg;
    res_t res_reg;
    res_t res_next;

    always_comb
    begin
        best_t b;
        b = '{pre: 2'd3, scl: 4'd15, rate: '0, found: 1'b0};
        for (int i = 0; i < NumPre; i++)
        begin
            if (in_best[i].found && in_best[i].rate > b.rate)
                b = in_best[i];
        end
        // fallback rate: clk / (7 * 32768), carried by the last row
        if (!b.found)
            b.rate = in_best[NumPre-1].rate;
        res_next.pre   = b.pre;
        res_next.scl   = b.scl;
        res_next.rate  = b.rate;
        res_next.above = (ClkW'(b.rate) > in_req.req_hz);
        res_next.zero  = (b.rate == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for the serial clock divider search
// depends on sbds_pkg and spi_baud_divider_search
`timescale 1ns / 1ps

module testbench;

    import sbds_pkg::*;

    localparam int ItemCount  = 850;
    localparam int CycleLimit = 400000;
    localparam int Latency    = 4;

    // idling phases
    typedef enum logic [1:0] {
        PH_NONE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } phase_t;

    // one directed row: inputs, and an expected result only where it is obvious
    typedef struct {
        logic [31:0] clock_hz;
        logic [31:0] target_hz;
        bit          typed;
        res_t        want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // clock_hz [31:0], target_hz [63:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // prescaler_code, scaler_code, achieved_hz, above, zero

    res_t   rate_queue[$];
    phase_t phase;
    int     mismatches = 0;
    int     cycles = 0;
    bit     hold_off;      // long receiver hold-off for the pressure phase
    int     hold_cycles;
    row_t   rows[$];

    spi_baud_divider_search uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // brute-force search over the 64 divisor pairs, prescaler-major
    function automatic res_t best_divider(input logic [31:0] clock_hz,
                                          input logic [31:0] target_hz);
        int unsigned pre_tab[4];
        int unsigned scl_tab[16];
        logic [31:0] rate;
        logic [31:0] top_rate;
        logic [31:0] chosen;
        res_t        r;
        pre_tab = '{2, 3, 5, 7};
        scl_tab = '{2, 4, 6, 8, 16, 32, 64, 128, 256, 512, 1024, 2048, 4096, 8192,
                    16384, 32768};
        top_rate = '0;
        r = '0;
        r.pre = 2'd3;
        r.scl = 4'd15;
        for (int p = 0; p < 4; p++)
            for (int s = 0; s < 16; s++)
            begin
                rate = clock_hz / (pre_tab[p] * scl_tab[s]);
                if (rate <= target_hz && rate > top_rate)
                begin
                    top_rate = rate;
                    r.pre = 2'(p);
                    r.scl = 4'(s);
                end
            end
        chosen = clock_hz / (pre_tab[r.pre] * scl_tab[r.scl]);
        r.rate  = chosen[29:0];
        r.above = (chosen > target_hz);
        r.zero  = (chosen == 0);
        return r;
    endfunction

    function automatic res_t fixed_res(input logic [1:0] p, input logic [3:0] s,
                                       input logic [29:0] rate, input bit above,
                                       input bit zero);
        res_t r;
        r.pre = p;
        r.scl = s;
        r.rate = rate;
        r.above = above;
        r.zero = zero;
        return r;
    endfunction

    function automatic bit send_gap();
        int pct;
        pct = (phase == PH_SEND_IDLE) ? 78 : (phase == PH_BOTH) ? 27 : 0;
        return $urandom_range(99) < pct;
    endfunction

    // present one transfer and hold it until taken
    task automatic send_item(input logic [31:0] clock_hz, input logic [31:0] target_hz,
                             input bit typed, input res_t want);
        while (send_gap())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {target_hz, clock_hz};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        rate_queue.push_back(typed ? want : best_divider(clock_hz, target_hz));
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (rate_queue.size() != 0)
            @(posedge clk);
    endtask

    // random operand shaped to land on every scaler range
    function automatic logic [31:0] rand_clock();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(2000000) ;
            2: return 32'($urandom()) >> $urandom_range(31);
            default: return 32'hFFFF_FFFF - $urandom_range(255);
        endcase
    endfunction

    function automatic logic [31:0] rand_target(input logic [31:0] clock_hz);
        logic [31:0] t;
        case ($urandom_range(3))
            0: t = $urandom();
            1: t = (clock_hz >> $urandom_range(2, 18)) + $urandom_range(3) - 1;
            2: t = $urandom_range(1000);
            default: t = 32'($urandom()) >> $urandom_range(31);
        endcase
        return (t == 0) ? 32'd1 : t;
    endfunction

    // receiver: random stalls per phase, plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= 0;
        end
        else if (hold_off && hold_cycles < 300)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles + 1;
        end
        else if (phase == PH_RECV_STALL)
            m_axis_tready <= ($urandom_range(99) >= 78);
        else if (phase == PH_BOTH)
            m_axis_tready <= ($urandom_range(99) >= 27);
        else
            m_axis_tready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.pre   = m_axis_tdata[1:0];
            got.scl   = m_axis_tdata[5:2];
            got.rate  = m_axis_tdata[35:6];
            got.above = m_axis_tdata[36];
            got.zero  = m_axis_tdata[37];
            if (rate_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = rate_queue.pop_front();
                if (got.pre !== want.pre)
                begin
                    $display("%0t: prescaler_code expected %0d actual %0d", $time,
                             want.pre, got.pre);
                    mismatches++;
                end
                if (got.scl !== want.scl)
                begin
                    $display("%0t: scaler_code expected %0d actual %0d", $time,
                             want.scl, got.scl);
                    mismatches++;
                end
                if (got.rate !== want.rate)
                begin
                    $display("%0t: achieved_hz expected %0d actual %0d", $time,
                             want.rate, got.rate);
                    mismatches++;
                end
                if (got.above !== want.above)
                begin
                    $display("%0t: above_request expected %0b actual %0b", $time,
                             want.above, got.above);
                    mismatches++;
                end
                if (got.zero !== want.zero)
                begin
                    $display("%0t: zero_rate expected %0b actual %0b", $time,
                             want.zero, got.zero);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] ck;
        res_t none;
        none = '0;
        hold_off = 1'b0;
        phase = PH_NONE;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;

        // zero clock, full clock with tiny and huge requests, zero request
        rows.push_back('{32'd0, 32'd1, 1'b1, fixed_res(2'd3, 4'd15, 30'd0, 1'b0, 1'b1)});
        rows.push_back('{32'd0, 32'hFFFF_FFFF, 1'b1,
                         fixed_res(2'd3, 4'd15, 30'd0, 1'b0, 1'b1)});
        rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                         fixed_res(2'd0, 4'd0, 30'h3FFF_FFFF, 1'b0, 1'b0)});
        // below the slowest rate: slowest pair with the rate above the request
        rows.push_back('{32'hFFFF_FFFF, 32'd1, 1'b1,
                         fixed_res(2'd3, 4'd15, 30'd18724, 1'b1, 1'b0)});
        rows.push_back('{32'hFFFF_FFFF, 32'd0, 1'b1,
                         fixed_res(2'd3, 4'd15, 30'd18724, 1'b1, 1'b0)});
        rows.push_back('{32'd3, 32'd1, 1'b1, fixed_res(2'd3, 4'd15, 30'd0, 1'b0, 1'b1)});
        rows.push_back('{32'd4, 32'd1, 1'b1, fixed_res(2'd0, 4'd0, 30'd1, 1'b0, 1'b0)});
        rows.push_back('{32'd48000000, 32'd1000000, 1'b0, none});
        rows.push_back('{32'd60000000, 32'd10000000, 1'b0, none});
        rows.push_back('{32'd120000000, 32'd12345, 1'b0, none});
        rows.push_back('{32'd229376, 32'd1, 1'b0, none});
        rows.push_back('{32'd229375, 32'd1, 1'b0, none});
        rows.push_back('{32'd8000000, 32'd333333, 1'b0, none});
        rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, none});
        rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, none});
        rows.push_back('{32'h8000_0000, 32'h0000_FFFF, 1'b0, none});
        rows.push_back('{32'd105, 32'd7, 1'b0, none});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].clock_hz, rows[i].target_hz, rows[i].typed, rows[i].want);
        go_idle();

        // random part across the idling phases
        for (int n = 0; n < ItemCount; n++)
        begin
            phase = phase_t'((n / 100) % 4);
            if (n == 400)
                hold_off = 1'b1;    // output held off while the input keeps offering
            if (n == 600)
                go_idle();          // sender pauses until the pipe drains
            ck = rand_clock();
            send_item(ck, rand_target(ck), 1'b0, none);
        end
        go_idle();
        repeat (Latency + 4) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
